/* sv/rrs_pkg.sv */
package rrs_pkg;

    // Sizing
    localparam int CORES         = 4;
    localparam int QUEUE_DEPTH   = 256;
    localparam int PID_BITS      = 8;

    localparam int PTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int CORE_SEL_BITS = (CORES > 1) ? $clog2(CORES) : 1;

    // Fixed field widths
    localparam int KIND_BITS     = 2;
    localparam int CORE_BITS     = 2;
    localparam int TASK_BITS     = 8;
    localparam int QUANTUM_BITS  = 16;
    localparam int CFG_IDX_BITS  = 2;

    // Request kinds
    localparam logic [KIND_BITS-1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_TICK    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_BLOCK   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_EXIT    = 2'd3;

    typedef logic [PTR_BITS-1:0]     ptr_t;
    typedef logic [CNT_BITS-1:0]     cnt_t;
    typedef logic [PID_BITS-1:0]     pid_t;
    typedef logic [QUANTUM_BITS-1:0] quantum_t;

    // Scheduler -> queue
    typedef struct packed {
        logic push;
        logic pop;
        pid_t pid;
    } queue_ctl_t;

    // Queue -> scheduler
    typedef struct packed {
        pid_t head_pid;
        cnt_t count;
        logic empty;
        logic full;
    } queue_sts_t;

    // Circular pointer increment
    function automatic ptr_t ptr_advance(input ptr_t p);
        ptr_t r;
        if (p == PTR_BITS'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_BITS'(1);
        return r;
    endfunction

endpackage

/* sv/rrs_if.sv */
// Event request channel
interface rrs_req_if;
    logic                          valid;
    logic                          ready;
    logic [rrs_pkg::KIND_BITS-1:0] kind;
    logic [rrs_pkg::CORE_BITS-1:0] core;
    logic [rrs_pkg::TASK_BITS-1:0] task_id;

    modport source (output valid, kind, core, task_id, input ready);
    modport sink   (input valid, kind, core, task_id, output ready);
endinterface

// Dispatch result channel
interface rrs_res_if;
    logic                          valid;
    logic                          ready;
    logic                          run_idle;
    logic [rrs_pkg::TASK_BITS-1:0] run_task;
    logic                          dropped;

    modport source (output valid, run_idle, run_task, dropped, input ready);
    modport sink   (input valid, run_idle, run_task, dropped, output ready);
endinterface

// Quantum register write channel
interface rrs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rrs_pkg::CFG_IDX_BITS-1:0] index;
    logic [rrs_pkg::QUANTUM_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/rrs_ram.sv */
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rrs_queue.sv */
// Shared ready queue: circular buffer in RAM with the head entry
// prefetched, so the front pid is available every cycle.
module rrs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  rrs_pkg::queue_ctl_t ctl,
    output rrs_pkg::queue_sts_t sts
);

    rrs_pkg::ptr_t head_reg, head_next;
    rrs_pkg::ptr_t tail_reg, tail_next;
    rrs_pkg::cnt_t count_reg, count_next;
    logic          bypass_reg, bypass_next;
    rrs_pkg::pid_t bypass_data_reg;
    rrs_pkg::pid_t ram_rdata;

    // Pointer and count updates
    always_comb
    begin
        head_next  = ctl.pop  ? rrs_pkg::ptr_advance(head_reg) : head_reg;
        tail_next  = ctl.push ? rrs_pkg::ptr_advance(tail_reg) : tail_reg;
        count_next = count_reg + rrs_pkg::CNT_BITS'(ctl.push)
                               - rrs_pkg::CNT_BITS'(ctl.pop);
        // RAM read returns old data when the new head is written now
        bypass_next = ctl.push && (tail_reg == head_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            bypass_reg <= bypass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_data_reg <= ctl.pid;
    end

    // Storage, read address always tracks the next head
    rrs_ram #(
        .WIDTH (rrs_pkg::PID_BITS),
        .DEPTH (rrs_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.push),
        .waddr (tail_reg),
        .wdata (ctl.pid),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    // Status
    always_comb
    begin
        sts.head_pid = bypass_reg ? bypass_data_reg : ram_rdata;
        sts.count    = count_reg;
        sts.empty    = (count_reg == '0);
        sts.full     = (count_reg == rrs_pkg::CNT_BITS'(rrs_pkg::QUEUE_DEPTH));
    end

endmodule

/* sv/multicore_round_robin_scheduler_core.sv */
// Channel  Modport  Payload                       Purpose
// req      sink     kind, core, task_id           scheduling events
// res      source   run_idle, run_task, dropped   one result per request
// cfg      sink     index, data                   quantum_core0..3 writes
//
// A request is held in the input register; the decision loads the result
// register when the result stage can advance, and the result is offered
// from there. One request is accepted per cycle while the result is not
// stalled; the single-port-write queue RAM with a prefetched head sets
// that figure. A stalled result holds the decision stage, and req.ready
// drops once the input register is also full. Reset clears the queue
// pointers, leaves every core idle and sets all quanta to 1.
module multicore_round_robin_scheduler_core (
    input  logic      clk,
    input  logic      rst_n,
    rrs_req_if.sink   req,
    rrs_res_if.source res,
    rrs_cfg_if.sink   cfg
);

    localparam int SB = rrs_pkg::CORE_SEL_BITS;

    // Input register
    logic                          in_valid_reg;
    logic [rrs_pkg::KIND_BITS-1:0] kind_reg;
    logic [rrs_pkg::CORE_BITS-1:0] core_reg;
    rrs_pkg::pid_t                 pid_reg;

    // Result register
    logic                          out_valid_reg;
    logic                          run_idle_reg, run_idle_next;
    logic [rrs_pkg::TASK_BITS-1:0] run_task_reg, run_task_next;
    logic                          dropped_reg, dropped_next;

    // Per-core state and quanta
    rrs_pkg::quantum_t quantum_reg   [rrs_pkg::CORES];
    rrs_pkg::quantum_t slice_left_reg[rrs_pkg::CORES];
    rrs_pkg::pid_t     task_reg      [rrs_pkg::CORES];
    logic              idle_reg      [rrs_pkg::CORES];

    rrs_pkg::quantum_t slice_next, slice_dec, cur_slice, cur_quantum;
    rrs_pkg::pid_t     task_next, cur_task;
    logic              idle_next, cur_idle;
    logic              core_upd;
    logic              in_range;
    logic [SB-1:0]     sel;

    logic advance;
    logic fire;

    rrs_pkg::queue_ctl_t q_ctl;
    rrs_pkg::queue_sts_t q_sts;

    // Handshake
    assign advance   = !out_valid_reg || res.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.valid && req.ready)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            kind_reg <= req.kind;
            core_reg <= req.core;
            pid_reg  <= req.task_id[rrs_pkg::PID_BITS-1:0];
        end
    end

    // Selected core state
    assign sel         = SB'(core_reg);
    assign in_range    = int'(core_reg) < rrs_pkg::CORES;
    assign cur_slice   = slice_left_reg[sel];
    assign cur_quantum = quantum_reg[sel];
    assign cur_task    = task_reg[sel];
    assign cur_idle    = idle_reg[sel];
    assign slice_dec   = cur_slice - rrs_pkg::QUANTUM_BITS'(1);

    // Scheduling decision
    always_comb
    begin
        q_ctl        = '0;
        q_ctl.pid    = pid_reg;
        dropped_next = 1'b0;
        slice_next   = cur_slice;
        task_next    = cur_task;
        idle_next    = cur_idle;
        core_upd     = 1'b0;

        if (fire)
        begin
            unique case (kind_reg)
                rrs_pkg::KIND_ENQUEUE:
                begin
                    if (q_sts.full)
                        dropped_next = 1'b1;
                    else
                        q_ctl.push = 1'b1;
                end
                rrs_pkg::KIND_TICK:
                begin
                    if (in_range)
                    begin
                        core_upd = 1'b1;
                        if (slice_dec != '0 && !cur_idle)
                            slice_next = slice_dec;
                        else
                        begin
                            slice_next = cur_quantum;
                            if (!q_sts.empty)
                            begin
                                // pop first, then requeue the preempted task
                                q_ctl.pop = 1'b1;
                                if (!cur_idle)
                                begin
                                    q_ctl.push = 1'b1;
                                    q_ctl.pid  = cur_task;
                                end
                                task_next = q_sts.head_pid;
                                idle_next = 1'b0;
                            end
                        end
                    end
                end
                rrs_pkg::KIND_BLOCK, rrs_pkg::KIND_EXIT:
                begin
                    if (in_range)
                    begin
                        core_upd   = 1'b1;
                        slice_next = cur_quantum;
                        if (!q_sts.empty)
                        begin
                            q_ctl.pop = 1'b1;
                            task_next = q_sts.head_pid;
                            idle_next = 1'b0;
                        end
                        else
                        begin
                            task_next = '0;
                            idle_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    dropped_next = 1'b0;
                end
            endcase
        end
    end

    // Result fields
    always_comb
    begin
        if (kind_reg == rrs_pkg::KIND_ENQUEUE)
        begin
            run_idle_next = 1'b0;
            run_task_next = '0;
        end
        else if (!in_range || idle_next)
        begin
            run_idle_next = 1'b1;
            run_task_next = '0;
        end
        else
        begin
            run_idle_next = 1'b0;
            run_task_next = rrs_pkg::TASK_BITS'(task_next);
        end
    end

    // Ready queue
    rrs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (q_ctl),
        .sts   (q_sts)
    );

    // Core state and quantum registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < rrs_pkg::CORES; c++)
            begin
                quantum_reg[c]    <= rrs_pkg::QUANTUM_BITS'(1);
                slice_left_reg[c] <= rrs_pkg::QUANTUM_BITS'(1);
                task_reg[c]       <= '0;
                idle_reg[c]       <= 1'b1;
            end
        end
        else
        begin
            if (cfg.valid && int'(cfg.index) < rrs_pkg::CORES)
                quantum_reg[SB'(cfg.index)] <= cfg.data;
            if (core_upd)
            begin
                slice_left_reg[sel] <= slice_next;
                task_reg[sel]       <= task_next;
                idle_reg[sel]       <= idle_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            run_idle_reg <= run_idle_next;
            run_task_reg <= run_task_next;
            dropped_reg  <= dropped_next;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.run_idle = run_idle_reg;
    assign res.run_task = run_task_reg;
    assign res.dropped  = dropped_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_sts.count <= rrs_pkg::CNT_BITS'(rrs_pkg::QUEUE_DEPTH))
        else $error("ready queue count above depth");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        fire && dropped_next |-> kind_reg == rrs_pkg::KIND_ENQUEUE && q_sts.full)
        else $error("drop flagged without a full queue");

    a_idle_no_task: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.run_idle |-> res.run_task == '0)
        else $error("idle result carries a pid");

    a_stall_freezes_queue: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> $stable(q_sts.count))
        else $error("queue changed while result stalled");

endmodule
